>>> rtl/nnss_pkg.sv
// ----------------------------------------------------------------------------
// nnss_pkg
// Shared types, codes and helpers for the nearest-neighbor scaler.
// ----------------------------------------------------------------------------
package nnss_pkg;

  localparam int DEF_MAX_DIM   = 128;
  localparam int DEF_MAX_SCALE = 8;

  localparam int COORD_W = 12;   // floor((lin+1)*scale) for lin+1 <= 255, scale <= 8.0
  localparam int FRAC_W  = 12;   // Q4.12 fraction bits
  localparam int ADDR_W  = 5;    // APB byte address
  localparam int DATA_W  = 32;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  localparam logic [2:0] REG_MODE         = 3'd0;
  localparam logic [2:0] REG_SCALE_COLS   = 3'd1;
  localparam logic [2:0] REG_SCALE_ROWS   = 3'd2;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd3;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd4;

  localparam logic [2:0] TAP_CENTER = 3'd0;
  localparam logic [2:0] TAP_UL     = 3'd1;
  localparam logic [2:0] TAP_UR     = 3'd2;
  localparam logic [2:0] TAP_DL     = 3'd3;
  localparam logic [2:0] TAP_DR     = 3'd4;

  localparam logic [1:0] MUL_Y0 = 2'd0;
  localparam logic [1:0] MUL_Y1 = 2'd1;
  localparam logic [1:0] MUL_X0 = 2'd2;
  localparam logic [1:0] MUL_X1 = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [15:0] scale_cols;
    logic [15:0] scale_rows;
    logic [7:0]  image_width;
    logic [7:0]  image_height;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_FETCH,
    ST_USE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       load_we;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       rd_en;
    logic [2:0] tap;
    logic       use_en;
    logic       emit_init;
    logic       emit_en;
  } dp_cmd_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] tap_en;
    logic       last;
  } dp_sts_t;

  // Channel-wise average of two RGB words, remainder dropped.
  function automatic logic [23:0] blend(input logic [23:0] a, input logic [23:0] b);
    logic [8:0] r;
    logic [8:0] g;
    logic [8:0] bl;
    r  = {1'b0, a[23:16]} + {1'b0, b[23:16]};
    g  = {1'b0, a[15:8]}  + {1'b0, b[15:8]};
    bl = {1'b0, a[7:0]}   + {1'b0, b[7:0]};
    return {r[8:1], g[8:1], bl[8:1]};
  endfunction

endpackage

>>> rtl/nearest_neighbor_scaler_with_smoothing_unit.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_scaler_with_smoothing_unit
// Nearest-neighbor pixel block scaler with optional diagonal smoothing.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken when start is high and busy is low. A load
//   command (cmd = 0) writes one RGB pixel into the frame store in that same
//   cycle and leaves busy low, so loads run one per cycle.
//   A render command (cmd = 1) raises busy. The block bounds are computed
//   on one shared 8x16 multiplier (row bounds, then column bounds), a check
//   state tests them, then the frame store is read one tap at a time: each
//   tap read (the center, plus each in-bounds diagonal in smoothing mode)
//   passes a fetch and a use state, a skipped tap only the fetch state.
//   Pixels follow one per cycle on valid, with last on the final one, and
//   busy drops after the last. A render that falls outside the image or
//   gives an empty block emits nothing and returns to idle after the check.
//   Result beats cannot be stalled: each is present for exactly one cycle.
//   Reset returns the controller to idle and the registers to their defaults;
//   the frame store is not cleared and must be loaded before it is rendered.
//   Write registers over the APB port only while busy is low; not enforced.
// ----------------------------------------------------------------------------
module nearest_neighbor_scaler_with_smoothing_unit #(
  parameter int MAX_DIM   = nnss_pkg::DEF_MAX_DIM,
  parameter int MAX_SCALE = nnss_pkg::DEF_MAX_SCALE
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cmd,
  input  logic [6:0]                  src_row,
  input  logic [6:0]                  src_col,
  input  logic [7:0]                  in_red,
  input  logic [7:0]                  in_green,
  input  logic [7:0]                  in_blue,
  output logic                        valid,
  output logic [9:0]                  dest_x,
  output logic [9:0]                  dest_y,
  output logic [7:0]                  out_red,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_blue,
  output logic                        last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nnss_pkg::ADDR_W-1:0] paddr,
  input  logic [nnss_pkg::DATA_W-1:0] pwdata,
  output logic [nnss_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import nnss_pkg::*;

  cfg_t    cfg;
  dp_cmd_t ctl;
  dp_sts_t sts;

  nnss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nnss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .valid (valid),
    .ctl   (ctl),
    .sts   (sts)
  );

  nnss_dp #(
    .MAX_DIM   (MAX_DIM),
    .MAX_SCALE (MAX_SCALE)
  ) u_dp (
    .clk       (clk),
    .cfg       (cfg),
    .ctl       (ctl),
    .sts       (sts),
    .src_row   (src_row),
    .src_col   (src_col),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .dest_x    (dest_x),
    .dest_y    (dest_y),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .last      (last)
  );

endmodule

>>> rtl/nnss_cfg.sv
// ----------------------------------------------------------------------------
// nnss_cfg
// APB register file holding mode, scale factors and image dimensions.
// ----------------------------------------------------------------------------
module nnss_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nnss_pkg::ADDR_W-1:0] paddr,
  input  logic [nnss_pkg::DATA_W-1:0] pwdata,
  output logic [nnss_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output nnss_pkg::cfg_t              cfg
);
  import nnss_pkg::*;

  logic [2:0] reg_idx;
  logic       wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr      = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= 1'b0;
      cfg.scale_cols   <= 16'd4096;
      cfg.scale_rows   <= 16'd4096;
      cfg.image_width  <= 8'd128;
      cfg.image_height <= 8'd128;
    end else if (wr) begin
      case (reg_idx)
        REG_MODE:         cfg.mode         <= pwdata[0];
        REG_SCALE_COLS:   cfg.scale_cols   <= pwdata[15:0];
        REG_SCALE_ROWS:   cfg.scale_rows   <= pwdata[15:0];
        REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[7:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:         prdata = {31'd0, cfg.mode};
      REG_SCALE_COLS:   prdata = {16'd0, cfg.scale_cols};
      REG_SCALE_ROWS:   prdata = {16'd0, cfg.scale_rows};
      REG_IMAGE_WIDTH:  prdata = {24'd0, cfg.image_width};
      REG_IMAGE_HEIGHT: prdata = {24'd0, cfg.image_height};
      default:          prdata = '0;
    endcase
  end

endmodule

>>> rtl/nnss_dp.sv
// ----------------------------------------------------------------------------
// nnss_dp
// Datapath: frame store, block-bounds multiplier, smoothing and the
// destination coordinate counters.
// ----------------------------------------------------------------------------
module nnss_dp #(
  parameter int MAX_DIM   = nnss_pkg::DEF_MAX_DIM,
  parameter int MAX_SCALE = nnss_pkg::DEF_MAX_SCALE
) (
  input  logic                 clk,
  input  nnss_pkg::cfg_t       cfg,
  input  nnss_pkg::dp_cmd_t    ctl,
  output nnss_pkg::dp_sts_t    sts,
  input  logic [6:0]           src_row,
  input  logic [6:0]           src_col,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  output logic [9:0]           dest_x,
  output logic [9:0]           dest_y,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic                 last
);
  import nnss_pkg::*;

  localparam int          DEPTH     = MAX_DIM * MAX_DIM;
  localparam int          AW        = $clog2(DEPTH);
  localparam logic [15:0] SCALE_LIM = 16'(MAX_SCALE * 4096);

  logic [23:0] mem [DEPTH];

  logic [6:0]         row;
  logic [6:0]         col;
  logic [COORD_W-1:0] y0, y1, x0, x1;
  logic [COORD_W-1:0] ycur, xcur;
  logic [23:0]        colour;
  logic [23:0]        rdata;

  logic [7:0]  w, h;
  logic [15:0] sr, sc;
  logic [7:0]  lin, row8, col8;
  logic [7:0]  mul_a;
  logic [15:0] mul_b;
  logic [23:0] prod;
  logic [7:0]  tap_row, tap_col;
  logic [31:0] raddr_wide, waddr_wide;
  logic        load_ok;
  logic        row_lo, row_hi, col_lo, col_hi;
  logic        x_wrap;

  // Dimensions above MAX_DIM behave as MAX_DIM; scales saturate at MAX_SCALE.
  assign w  = ({3'b0, cfg.image_width}  > 11'(MAX_DIM)) ? 8'(MAX_DIM) : cfg.image_width;
  assign h  = ({3'b0, cfg.image_height} > 11'(MAX_DIM)) ? 8'(MAX_DIM) : cfg.image_height;
  assign sr = (cfg.scale_rows > SCALE_LIM) ? SCALE_LIM : cfg.scale_rows;
  assign sc = (cfg.scale_cols > SCALE_LIM) ? SCALE_LIM : cfg.scale_cols;

  assign row8 = {1'b0, row};
  assign col8 = {1'b0, col};
  assign lin  = h - 8'd1 - row8;

  always_comb begin
    case (ctl.mul_step)
      MUL_Y0:  mul_a = lin;
      MUL_Y1:  mul_a = lin + 8'd1;
      MUL_X0:  mul_a = col8;
      default: mul_a = col8 + 8'd1;
    endcase
    mul_b = (ctl.mul_step == MUL_Y0 || ctl.mul_step == MUL_Y1) ? sr : sc;
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      row <= src_row;
      col <= src_col;
    end
    if (ctl.mul_en) begin
      case (ctl.mul_step)
        MUL_Y0:  y0 <= prod[FRAC_W +: COORD_W];
        MUL_Y1:  y1 <= prod[FRAC_W +: COORD_W];
        MUL_X0:  x0 <= prod[FRAC_W +: COORD_W];
        default: x1 <= prod[FRAC_W +: COORD_W];
      endcase
    end
  end

  // Neighbor bounds for the smoothing taps.
  assign row_lo = (row != 7'd0);
  assign col_lo = (col != 7'd0);
  assign row_hi = ((row8 + 8'd1) < h);
  assign col_hi = ((col8 + 8'd1) < w);

  assign sts.ok = (row8 < h) && (col8 < w) && (y1 > y0) && (x1 > x0);
  assign sts.tap_en[0] = 1'b1;
  assign sts.tap_en[1] = cfg.mode & row_lo & col_lo;
  assign sts.tap_en[2] = cfg.mode & row_lo & col_hi;
  assign sts.tap_en[3] = cfg.mode & col_lo & row_hi;
  assign sts.tap_en[4] = cfg.mode & row_hi & col_hi;

  always_comb begin
    case (ctl.tap)
      TAP_UL: begin
        tap_row = row8 - 8'd1;
        tap_col = col8 - 8'd1;
      end
      TAP_UR: begin
        tap_row = row8 - 8'd1;
        tap_col = col8 + 8'd1;
      end
      TAP_DL: begin
        tap_row = row8 + 8'd1;
        tap_col = col8 - 8'd1;
      end
      TAP_DR: begin
        tap_row = row8 + 8'd1;
        tap_col = col8 + 8'd1;
      end
      default: begin
        tap_row = row8;
        tap_col = col8;
      end
    endcase
  end

  assign raddr_wide = 32'(tap_row) * 32'(MAX_DIM) + 32'(tap_col);
  assign waddr_wide = 32'(src_row) * 32'(MAX_DIM) + 32'(src_col);
  assign load_ok    = (32'(src_row) < 32'(MAX_DIM)) && (32'(src_col) < 32'(MAX_DIM));

  always_ff @(posedge clk) begin
    if (ctl.load_we && load_ok) begin
      mem[waddr_wide[AW-1:0]] <= {in_red, in_green, in_blue};
    end
    if (ctl.rd_en) begin
      rdata <= mem[raddr_wide[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.use_en) begin
      colour <= (ctl.tap == TAP_CENTER) ? rdata : blend(colour, rdata);
    end
  end

  // Rows run from the top of the block down, columns left to right.
  assign x_wrap = ((xcur + COORD_W'(1)) == x1);

  always_ff @(posedge clk) begin
    if (ctl.emit_init) begin
      ycur <= y1 - COORD_W'(1);
      xcur <= x0;
    end else if (ctl.emit_en) begin
      if (x_wrap) begin
        xcur <= x0;
        ycur <= ycur - COORD_W'(1);
      end else begin
        xcur <= xcur + COORD_W'(1);
      end
    end
  end

  assign sts.last = (ycur == y0) && x_wrap;

  assign dest_x    = xcur[9:0];
  assign dest_y    = ycur[9:0];
  assign out_red   = colour[23:16];
  assign out_green = colour[15:8];
  assign out_blue  = colour[7:0];
  assign last      = sts.last;

endmodule

>>> rtl/nnss_ctrl.sv
// ----------------------------------------------------------------------------
// nnss_ctrl
// Controller: sequences bounds multiply, frame store taps and pixel emission.
// ----------------------------------------------------------------------------
module nnss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              cmd,
  output logic              busy,
  output logic              valid,
  output nnss_pkg::dp_cmd_t ctl,
  input  nnss_pkg::dp_sts_t sts
);
  import nnss_pkg::*;

  state_t     state, state_next;
  logic [1:0] step, step_next;
  logic [2:0] tap, tap_next;
  logic       accept;

  assign accept = start & (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      tap   <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      tap   <= tap_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    tap_next   = tap;
    case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_RENDER) begin
          state_next = ST_MUL;
          step_next  = MUL_Y0;
        end
      end
      ST_MUL: begin
        step_next = step + 2'd1;
        if (step == MUL_X1) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        tap_next   = TAP_CENTER;
        state_next = sts.ok ? ST_FETCH : ST_IDLE;
      end
      ST_FETCH: begin
        if (sts.tap_en[tap]) begin
          state_next = ST_USE;
        end else if (tap == TAP_DR) begin
          state_next = ST_EMIT;
        end else begin
          tap_next = tap + 3'd1;
        end
      end
      ST_USE: begin
        if (tap == TAP_DR) begin
          state_next = ST_EMIT;
        end else begin
          tap_next   = tap + 3'd1;
          state_next = ST_FETCH;
        end
      end
      ST_EMIT: begin
        if (sts.last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.mul_step  = step;
    ctl.tap       = tap;
    ctl.capture   = accept && cmd == CMD_RENDER;
    ctl.load_we   = accept && cmd == CMD_LOAD;
    busy          = (state != ST_IDLE);
    valid         = 1'b0;
    case (state)
      ST_MUL:   ctl.mul_en    = 1'b1;
      ST_CHECK: ctl.emit_init = 1'b1;
      ST_FETCH: ctl.rd_en     = sts.tap_en[tap];
      ST_USE:   ctl.use_en    = 1'b1;
      ST_EMIT: begin
        ctl.emit_en = 1'b1;
        valid       = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> bench/tb_nearest_neighbor_scaler_with_smoothing_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_scaler_with_smoothing_unit
// Self-checking bench for the nearest-neighbor block scaler. A driver feeds
// load and render beats in random bursts, a predictor keeps its own frame
// copy and register set and queues the pixels each render must produce, and
// a monitor compares every emitted pixel with the oldest queued one. Register
// settings change over APB between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_scaler_with_smoothing_unit;
  import nnss_pkg::*;

  localparam int          STORE_SIZE = DEF_MAX_DIM * DEF_MAX_DIM;
  localparam int unsigned SCALE_LIM  = DEF_MAX_SCALE << FRAC_W;

  typedef struct {
    logic       cmd;
    logic [6:0] row;
    logic [6:0] col;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } scaler_beat_t;

  typedef struct {
    logic [9:0] x;
    logic [9:0] y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              start    = 1'b0;
  logic              cmd      = CMD_LOAD;
  logic [6:0]        src_row  = '0;
  logic [6:0]        src_col  = '0;
  logic [7:0]        in_red   = '0;
  logic [7:0]        in_green = '0;
  logic [7:0]        in_blue  = '0;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [DATA_W-1:0] pwdata   = '0;
  logic              busy;
  logic              valid;
  logic [9:0]        dest_x;
  logic [9:0]        dest_y;
  logic [7:0]        out_red;
  logic [7:0]        out_green;
  logic [7:0]        out_blue;
  logic              last;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Register values as last written, and the frame contents as loaded.
  cfg_t        scaler_cfg = '{mode: 1'b0, scale_cols: 16'd4096, scale_rows: 16'd4096,
                              image_width: 8'd128, image_height: 8'd128};
  logic [23:0] frame_copy [STORE_SIZE];
  bit          load_queued [STORE_SIZE];

  scaler_beat_t beat_q [$];
  pixel_t       expected_px [$];
  scaler_beat_t cur_beat;
  int unsigned  beats_queued = 0;
  int unsigned  mismatches   = 0;
  int unsigned  gap_left     = 0;
  int unsigned  burst_left   = 0;

  nearest_neighbor_scaler_with_smoothing_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .src_row   (src_row),
    .src_col   (src_col),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .valid     (valid),
    .dest_x    (dest_x),
    .dest_y    (dest_y),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .last      (last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  function automatic int unsigned eff_dim(input logic [7:0] d);
    return (d > DEF_MAX_DIM) ? DEF_MAX_DIM : d;
  endfunction

  function automatic int unsigned slot(input int unsigned r, input int unsigned c);
    return r * DEF_MAX_DIM + c;
  endfunction

  function automatic logic [23:0] avg_rgb(input logic [23:0] a, input logic [23:0] b);
    logic [23:0] res;
    logic [8:0]  sum;
    for (int ch = 0; ch < 3; ch++) begin
      sum = a[ch*8 +: 8] + b[ch*8 +: 8];
      res[ch*8 +: 8] = sum[8:1];
    end
    return res;
  endfunction

  // Applies one accepted beat to the frame copy, and for a render queues
  // every pixel of the scaled block in emission order.
  function automatic void predict_beat(input scaler_beat_t b);
    int unsigned w, h, lin, sr, sc, y0, y1, x0, x1, y, x;
    logic [23:0] rgb;
    pixel_t      px;
    if (b.cmd == CMD_LOAD) begin
      frame_copy[slot(b.row, b.col)] = {b.red, b.green, b.blue};
      return;
    end
    w = eff_dim(scaler_cfg.image_width);
    h = eff_dim(scaler_cfg.image_height);
    if (b.row >= h || b.col >= w)
      return;
    lin = h - 1 - b.row;
    sr  = (scaler_cfg.scale_rows > SCALE_LIM) ? SCALE_LIM : scaler_cfg.scale_rows;
    sc  = (scaler_cfg.scale_cols > SCALE_LIM) ? SCALE_LIM : scaler_cfg.scale_cols;
    y0  = (lin * sr) >> FRAC_W;
    y1  = ((lin + 1) * sr) >> FRAC_W;
    x0  = (b.col * sc) >> FRAC_W;
    x1  = ((b.col + 1) * sc) >> FRAC_W;
    if (y1 <= y0 || x1 <= x0)
      return;
    rgb = frame_copy[slot(b.row, b.col)];
    if (scaler_cfg.mode) begin
      // Diagonals are folded in one after another, so later ones weigh more.
      if (b.row != 0 && b.col != 0)
        rgb = avg_rgb(rgb, frame_copy[slot(b.row - 1, b.col - 1)]);
      if (b.row != 0 && b.col + 1 < w)
        rgb = avg_rgb(rgb, frame_copy[slot(b.row - 1, b.col + 1)]);
      if (b.col != 0 && b.row + 1 < h)
        rgb = avg_rgb(rgb, frame_copy[slot(b.row + 1, b.col - 1)]);
      if (b.row + 1 < h && b.col + 1 < w)
        rgb = avg_rgb(rgb, frame_copy[slot(b.row + 1, b.col + 1)]);
    end
    for (y = y1; y > y0; y--) begin
      for (x = x0; x < x1; x++) begin
        px.x     = 10'(x);
        px.y     = 10'(y - 1);
        px.red   = rgb[23:16];
        px.green = rgb[15:8];
        px.blue  = rgb[7:0];
        px.last  = (y - 1 == y0) && (x + 1 == x1);
        expected_px.push_back(px);
      end
    end
  endfunction

  function automatic void push_load(input int unsigned r, input int unsigned c,
                                    input logic [23:0] rgb);
    scaler_beat_t b;
    b.cmd   = CMD_LOAD;
    b.row   = 7'(r);
    b.col   = 7'(c);
    b.red   = rgb[23:16];
    b.green = rgb[15:8];
    b.blue  = rgb[7:0];
    beat_q.push_back(b);
    load_queued[slot(r, c)] = 1'b1;
    beats_queued++;
  endfunction

  // Queues a render, preceded by loads of any pixel it could read that has
  // never been written, so no render ever touches an undefined entry.
  function automatic void push_render(input int unsigned r, input int unsigned c);
    scaler_beat_t b;
    int unsigned  w, h;
    int           rr, cc;
    w = eff_dim(scaler_cfg.image_width);
    h = eff_dim(scaler_cfg.image_height);
    if (r < h && c < w) begin
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          rr = int'(r) + dr;
          cc = int'(c) + dc;
          if ((dr == dc || dr == -dc) && rr >= 0 && rr < int'(h) && cc >= 0
              && cc < int'(w) && !load_queued[slot(rr, cc)])
            push_load(rr, cc, 24'($urandom));
        end
      end
    end
    b.cmd   = CMD_RENDER;
    b.row   = 7'(r);
    b.col   = 7'(c);
    b.red   = 8'($urandom);
    b.green = 8'($urandom);
    b.blue  = 8'($urandom);
    beat_q.push_back(b);
    beats_queued++;
  endfunction

  function automatic void fill_random(input int unsigned n);
    int unsigned stop_at, w, h, pick;
    stop_at = beats_queued + n;
    w = eff_dim(scaler_cfg.image_width);
    h = eff_dim(scaler_cfg.image_height);
    while (beats_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 60 && w != 0 && h != 0)
        push_render($urandom_range(0, h - 1), $urandom_range(0, w - 1));
      else if (pick < 75)
        push_render($urandom_range(0, 127), $urandom_range(0, 127));
      else
        push_load($urandom_range(0, 127), $urandom_range(0, 127), 24'($urandom));
    end
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'($urandom_range(SCALE_LIM + 1, 16'hFFFF));
      2:       return 16'(SCALE_LIM);
      3, 4:    return 16'($urandom_range(1, 4095));
      default: return 16'($urandom_range(4096, SCALE_LIM));
    endcase
  endfunction

  function automatic logic [7:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'($urandom_range(DEF_MAX_DIM + 1, 255));
      2:       return 8'(DEF_MAX_DIM);
      default: return 8'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE:         scaler_cfg.mode         = val[0];
      REG_SCALE_COLS:   scaler_cfg.scale_cols   = val[15:0];
      REG_SCALE_ROWS:   scaler_cfg.scale_rows   = val[15:0];
      REG_IMAGE_WIDTH:  scaler_cfg.image_width  = val[7:0];
      REG_IMAGE_HEIGHT: scaler_cfg.image_height = val[7:0];
      default: ;
    endcase
  endtask

  // Unused upper data bits carry noise; the block must ignore them.
  task automatic set_config(input logic m, input logic [15:0] sc, input logic [15:0] sr,
                            input logic [7:0] w, input logic [7:0] h);
    write_reg(REG_MODE,         {31'($urandom), m});
    write_reg(REG_SCALE_COLS,   {16'($urandom), sc});
    write_reg(REG_SCALE_ROWS,   {16'($urandom), sr});
    write_reg(REG_IMAGE_WIDTH,  {24'($urandom), w});
    write_reg(REG_IMAGE_HEIGHT, {24'($urandom), h});
  endtask

  // A render with nothing to emit still keeps the block busy, so some
  // settle time follows the last expected pixel. The state is sampled on
  // the falling edge, after the driver's updates have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (beat_q.size() != 0 || start || busy || expected_px.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        predict_beat(cur_beat);
      if (!(start && busy)) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (beat_q.size() == 0) begin
          start <= 1'b0;
        end else begin
          cur_beat = beat_q.pop_front();
          cmd      <= cur_beat.cmd;
          src_row  <= cur_beat.row;
          src_col  <= cur_beat.col;
          in_red   <= cur_beat.red;
          in_green <= cur_beat.green;
          in_blue  <= cur_beat.blue;
          start    <= 1'b1;
          if (burst_left != 0)
            burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1:       gap_left = $urandom_range(1, 3);
              2:       gap_left = $urandom_range(4, 20);
              default: gap_left = $urandom_range(21, 60);
            endcase
          end
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [9:0] want,
                                      input logic [9:0] got);
    if (got !== want) begin
      if (mismatches < 40)
        $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && valid) begin
      if (expected_px.size() == 0) begin
        if (mismatches < 40)
          $error("pixel beat with none expected: x=%0d y=%0d", dest_x, dest_y);
        mismatches++;
      end else begin
        check_field("dest_x",    expected_px[0].x,     dest_x);
        check_field("dest_y",    expected_px[0].y,     dest_y);
        check_field("out_red",   expected_px[0].red,   out_red);
        check_field("out_green", expected_px[0].green, out_green);
        check_field("out_blue",  expected_px[0].blue,  out_blue);
        check_field("last",      expected_px[0].last,  last);
        void'(expected_px.pop_front());
      end
    end
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : main_seq
    int phase;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one-to-one mapping, corners and color extremes.
    push_load(0, 0, 24'h000000);
    push_load(127, 127, 24'hFFFFFF);
    push_load(0, 127, 24'hFF00FF);
    push_render(0, 0);
    push_render(127, 127);
    push_render(0, 127);
    wait_idle();

    // Full 8x blocks with smoothing, reaching destination coordinate 1023.
    set_config(1'b1, 16'(SCALE_LIM), 16'(SCALE_LIM), 8'd128, 8'd128);
    push_render(127, 127);
    push_render(0, 0);
    push_render(64, 64);
    wait_idle();

    // Scales above 8.0 saturate and dimensions above 128 clamp.
    set_config(1'b1, 16'hFFFF, 16'h9000, 8'hFF, 8'hC8);
    push_render(127, 0);
    push_render(3, 126);
    wait_idle();

    // Zero height: every render is outside the image.
    set_config(1'b0, 16'h0800, 16'h1800, 8'd4, 8'd0);
    push_render(0, 0);
    wait_idle();

    // Reduced scale gives empty and single-column blocks; outside renders.
    set_config(1'b0, 16'h0800, 16'h1800, 8'd4, 8'd6);
    push_render(0, 0);
    push_render(2, 1);
    push_render(10, 1);
    push_render(1, 7);
    wait_idle();

    // Zero scale always yields an empty block.
    set_config(1'b1, 16'd0, 16'd4096, 8'd4, 8'd4);
    push_render(1, 1);
    wait_idle();

    phase = 0;
    while (phase < 4) begin
      set_config(1'($urandom), pick_scale(), pick_scale(), pick_dim(), pick_dim());
      // The sender drains completely halfway through each phase.
      fill_random(9);
      wait_idle();
      fill_random(9);
      if (phase < 3)
        wait_idle();
      phase++;
    end

    do @(negedge clk);
    while (beat_q.size() != 0 || start);
    for (int i = 0; i < 2000 && expected_px.size() != 0; i++)
      @(posedge clk);
    repeat (30) @(posedge clk);
    if (expected_px.size() != 0) begin
      $error("%0d expected pixels never arrived", expected_px.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
rtl/nnss_pkg.sv
rtl/nnss_cfg.sv
rtl/nnss_dp.sv
rtl/nnss_ctrl.sv
rtl/nearest_neighbor_scaler_with_smoothing_unit.sv
bench/tb_nearest_neighbor_scaler_with_smoothing_unit.sv
